### design/gsfc_pkg.sv
// gsfc_pkg: types, codes and constants shared by the gear selector frame controller.
// No dependencies. Used by gsfc_front, gsfc_cmdq, gsfc_back and the top level.
`timescale 1ns / 1ps
`default_nettype none
package gsfc_pkg;

   // register widths
   localparam int TX_ID_W   = 11;
   localparam int RX_ID_W   = 11;
   localparam int SEED_W    = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DW    = 11;

   // reset values of the registers
   localparam logic [TX_ID_W-1:0] TX_ID_RST = 11'd537;
   localparam logic [RX_ID_W-1:0] RX_ID_RST = 11'd601;
   localparam logic [SEED_W-1:0]  SEED_RST  = 8'd12;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TX_ID = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RX_ID = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED  = 2'd2;

   // received frame checks
   localparam logic [3:0] RX_LEN = 4'd3;

   // lever word decode: position nibble and flag bits
   localparam logic [3:0] POS_D_FULL   = 4'h8;
   localparam logic [3:0] POS_R_FULL   = 4'h4;
   localparam logic [3:0] POS_R_LITTLE = 4'h2;
   localparam logic [3:0] POS_D_LITTLE = 4'h6;
   localparam int LEVER_CHANGE_BIT = 10;
   localparam int LEVER_P_BIT      = 8;
   localparam int LEVER_B_BIT      = 6;

   // queue depths, powers of two so the pointers wrap on their own
   localparam int CQ_DEPTH = 4;
   localparam int CQ_AW    = $clog2(CQ_DEPTH);
   localparam int RQ_DEPTH = 4;
   localparam int RQ_AW    = $clog2(RQ_DEPTH);

   typedef enum logic [2:0] {
      LAMP_OFF     = 3'd0,
      LAMP_ON      = 3'd1,
      LAMP_BACKLIT = 3'd3,
      LAMP_BLINK   = 3'd4
   } lamp_type;

   typedef enum logic [2:0] {
      ST_CHANGED = 3'd0,
      ST_SAME    = 3'd1,
      ST_CK_BAD  = 3'd2,
      ST_LEN_BAD = 3'd3,
      ST_OTHER   = 3'd4
   } status_type;

   typedef struct packed {
      lamp_type p;
      lamp_type r;
      lamp_type n;
      lamp_type d;
      lamp_type b;
   } lamps_type;

   // classified transaction handed from front to back
   typedef struct packed {
      logic        tick;
      logic        valid;
      status_type  status;
      logic [15:0] word;
   } cmd_type;

   typedef struct packed {
      logic               kind;
      logic [63:0]        tx_data;
      logic [TX_ID_W-1:0] tx_id;
      lamps_type          lamps;
      status_type         status;
   } res_type;

endpackage
`default_nettype wire

### design/gsfc_front.sv
// gsfc_front: accepts request transactions and classifies them (id, length, checksum).
// Depends on gsfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gsfc_front (
   input  wire logic                         req_push,
   output logic                              req_full,
   input  wire logic                         req_cmd,
   input  wire logic [31:0]                  req_frame_id,
   input  wire logic [3:0]                   req_frame_len,
   input  wire logic [7:0]                   req_rx_byte0,
   input  wire logic [7:0]                   req_rx_byte1,
   input  wire logic [7:0]                   req_rx_byte2,
   input  wire logic [gsfc_pkg::RX_ID_W-1:0] rx_frame_id,
   input  wire logic                         cq_full,
   output logic                              cq_push,
   output gsfc_pkg::cmd_type                 cq_cmd
);

   logic [3:0] nib_sum;
   logic       ck_ok;

   assign req_full = cq_full;
   assign cq_push  = req_push & ~cq_full;

   // nibble sum modulo 16 with the counter nibble, inverted for the checksum nibble
   assign nib_sum = req_rx_byte1[7:4] + req_rx_byte1[3:0] + req_rx_byte2[7:4]
                  + req_rx_byte2[3:0] + req_rx_byte0[3:0];
   assign ck_ok   = (req_rx_byte0[7:4] == ~nib_sum);

   always_comb begin
      cq_cmd.tick   = req_cmd;
      cq_cmd.valid  = 1'b0;
      cq_cmd.status = gsfc_pkg::ST_OTHER;
      cq_cmd.word   = {req_rx_byte1, req_rx_byte2};
      if (!req_cmd) begin
         priority if (req_frame_id != {{(32-gsfc_pkg::RX_ID_W){1'b0}}, rx_frame_id}) begin
            cq_cmd.status = gsfc_pkg::ST_OTHER;
         end else if (req_frame_len != gsfc_pkg::RX_LEN) begin
            cq_cmd.status = gsfc_pkg::ST_LEN_BAD;
         end else if (!ck_ok) begin
            cq_cmd.status = gsfc_pkg::ST_CK_BAD;
         end else begin
            cq_cmd.valid  = 1'b1;
            cq_cmd.status = gsfc_pkg::ST_SAME;
         end
      end
   end

endmodule
`default_nettype wire

### design/gsfc_cmdq.sv
// gsfc_cmdq: short queue of classified transactions between front and back.
// Depends on gsfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gsfc_cmdq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire gsfc_pkg::cmd_type din,
   output logic                   full,
   input  wire logic              pop,
   output gsfc_pkg::cmd_type      dout,
   output logic                   empty
);

   gsfc_pkg::cmd_type                q_ff [gsfc_pkg::CQ_DEPTH];
   logic [gsfc_pkg::CQ_AW-1:0]       wptr_ff, wptr_in;
   logic [gsfc_pkg::CQ_AW-1:0]       rptr_ff, rptr_in;
   logic [gsfc_pkg::CQ_AW:0]         count_ff, count_in;
   logic                             do_push, do_pop;

   assign full    = (count_ff == (gsfc_pkg::CQ_AW+1)'(gsfc_pkg::CQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign dout    = q_ff[rptr_ff];

   always_comb begin
      wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + {{gsfc_pkg::CQ_AW{1'b0}}, do_push}
                          - {{gsfc_pkg::CQ_AW{1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wptr_ff] <= din;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (gsfc_pkg::CQ_AW+1)'(gsfc_pkg::CQ_DEPTH))
      else $error("command queue count beyond depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0 && count_ff != (gsfc_pkg::CQ_AW+1)'(gsfc_pkg::CQ_DEPTH))
         |-> (wptr_ff != rptr_ff))
      else $error("command queue pointers disagree with count");

   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      !(full && empty))
      else $error("command queue full and empty at once");

endmodule
`default_nettype wire

### design/gsfc_back.sv
// gsfc_back: applies transactions to the lamp state machine and transmit counter,
// builds status frames and holds the result queue. Depends on gsfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gsfc_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gsfc_pkg::cmd_type             cmd,
   input  wire logic                          cq_empty,
   output logic                               cq_pop,
   input  wire logic [gsfc_pkg::TX_ID_W-1:0]  tx_frame_id,
   input  wire logic [gsfc_pkg::SEED_W-1:0]   tx_seed,
   input  wire logic                          res_pop,
   output logic                               res_empty,
   output gsfc_pkg::res_type                  res
);

   gsfc_pkg::lamps_type        lamps_ff, lamps_in, lever_lamps;
   logic [15:0]                last_word_ff, last_word_in;
   logic [3:0]                 tx_ctr_ff, tx_ctr_in;
   gsfc_pkg::res_type          rq_ff [gsfc_pkg::RQ_DEPTH];
   logic [gsfc_pkg::RQ_AW-1:0] wptr_ff, wptr_in;
   logic [gsfc_pkg::RQ_AW-1:0] rptr_ff, rptr_in;
   logic [gsfc_pkg::RQ_AW:0]   count_ff, count_in;
   logic                       fire, do_pop, changed, nchk;
   logic [3:0]                 pos;
   logic [31:0]                lamp_word;
   logic [3:0]                 nib_sum, ck_nib;
   gsfc_pkg::res_type          res_new;

   assign res_empty = (count_ff == '0);
   assign fire      = ~cq_empty & (count_ff != (gsfc_pkg::RQ_AW+1)'(gsfc_pkg::RQ_DEPTH));
   assign cq_pop    = fire;
   assign do_pop    = res_pop & ~res_empty;
   assign res       = rq_ff[rptr_ff];
   assign changed   = (cmd.word != last_word_ff);
   assign pos       = cmd.word[15:12];

   // lever rules; the full reverse position also runs the neutral rule
   always_comb begin
      lever_lamps = lamps_ff;
      nchk        = 1'b0;
      priority if (pos == gsfc_pkg::POS_D_FULL) begin
         lever_lamps = '{gsfc_pkg::LAMP_OFF, gsfc_pkg::LAMP_BACKLIT, gsfc_pkg::LAMP_BACKLIT,
                         gsfc_pkg::LAMP_ON, gsfc_pkg::LAMP_BACKLIT};
      end else if (pos == gsfc_pkg::POS_R_FULL) begin
         lever_lamps = '{gsfc_pkg::LAMP_OFF, gsfc_pkg::LAMP_ON, gsfc_pkg::LAMP_BACKLIT,
                         gsfc_pkg::LAMP_BACKLIT, gsfc_pkg::LAMP_OFF};
         nchk        = 1'b1;
      end else if (pos == gsfc_pkg::POS_R_LITTLE || pos == gsfc_pkg::POS_D_LITTLE) begin
         nchk = 1'b1;
      end else begin
         nchk = 1'b0;
      end
      if (nchk && (lever_lamps.r == gsfc_pkg::LAMP_ON || lever_lamps.d == gsfc_pkg::LAMP_ON)
          && !cmd.word[gsfc_pkg::LEVER_CHANGE_BIT]) begin
         lever_lamps = '{gsfc_pkg::LAMP_BACKLIT, gsfc_pkg::LAMP_BACKLIT, gsfc_pkg::LAMP_ON,
                         gsfc_pkg::LAMP_BACKLIT, gsfc_pkg::LAMP_OFF};
      end
      if (cmd.word[gsfc_pkg::LEVER_P_BIT] && lever_lamps.n == gsfc_pkg::LAMP_ON) begin
         lever_lamps = '{gsfc_pkg::LAMP_ON, gsfc_pkg::LAMP_BACKLIT, gsfc_pkg::LAMP_OFF,
                         gsfc_pkg::LAMP_BACKLIT, gsfc_pkg::LAMP_OFF};
      end
      if (cmd.word[gsfc_pkg::LEVER_B_BIT] && lever_lamps.d == gsfc_pkg::LAMP_ON) begin
         lever_lamps.b = (lever_lamps.b == gsfc_pkg::LAMP_ON) ? gsfc_pkg::LAMP_BACKLIT
                                                              : gsfc_pkg::LAMP_ON;
      end
   end

   // packed lamp word for bytes 1 to 4 of the status frame
   always_comb begin
      lamp_word        = '0;
      lamp_word[3:1]   = lamps_ff.p;
      lamp_word[10:8]  = lamps_ff.d;
      lamp_word[13:11] = lamps_ff.n;
      lamp_word[16:14] = lamps_ff.r;
      lamp_word[23:21] = lamps_ff.b;
   end

   always_comb begin
      nib_sum = tx_ctr_ff;
      for (int k = 0; k < 8; k++) begin
         nib_sum = nib_sum + lamp_word[4*k +: 4];
      end
      ck_nib = ~nib_sum - tx_seed[3:0];
   end

   always_comb begin
      lamps_in     = lamps_ff;
      last_word_in = last_word_ff;
      tx_ctr_in    = tx_ctr_ff;
      res_new      = '{kind: 1'b0, tx_data: '0, tx_id: '0, lamps: lamps_ff,
                       status: cmd.status};
      if (fire) begin
         if (cmd.tick) begin
            tx_ctr_in       = tx_ctr_ff + 1'b1;
            res_new.kind    = 1'b1;
            res_new.tx_data = {24'd0, lamp_word, ck_nib, tx_ctr_ff};
            res_new.tx_id   = tx_frame_id;
            res_new.status  = gsfc_pkg::ST_OTHER;
         end else if (cmd.valid) begin
            last_word_in = cmd.word;
            if (changed) begin
               lamps_in       = lever_lamps;
               res_new.status = gsfc_pkg::ST_CHANGED;
            end else begin
               res_new.status = gsfc_pkg::ST_SAME;
            end
         end
         res_new.lamps = lamps_in;
      end
   end

   always_comb begin
      wptr_in  = fire ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + {{gsfc_pkg::RQ_AW{1'b0}}, fire}
                          - {{gsfc_pkg::RQ_AW{1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lamps_ff     <= '{gsfc_pkg::LAMP_ON, gsfc_pkg::LAMP_BACKLIT, gsfc_pkg::LAMP_OFF,
                           gsfc_pkg::LAMP_BACKLIT, gsfc_pkg::LAMP_OFF};
         last_word_ff <= '0;
         tx_ctr_ff    <= '0;
         wptr_ff      <= '0;
         rptr_ff      <= '0;
         count_ff     <= '0;
      end else begin
         lamps_ff     <= lamps_in;
         last_word_ff <= last_word_in;
         tx_ctr_ff    <= tx_ctr_in;
         wptr_ff      <= wptr_in;
         rptr_ff      <= rptr_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rq_ff[wptr_ff] <= res_new;
      end
   end

   a_rq_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (gsfc_pkg::RQ_AW+1)'(gsfc_pkg::RQ_DEPTH))
      else $error("result queue count beyond depth");

   a_tick_ctr: assert property (@(posedge clock) disable iff (reset)
      (fire && cmd.tick) |=> (tx_ctr_ff == $past(tx_ctr_ff) + 4'd1))
      else $error("transmit counter did not advance on tick");

   a_reject_hold: assert property (@(posedge clock) disable iff (reset)
      (fire && !cmd.tick && !cmd.valid) |=> ($stable(lamps_ff) && $stable(last_word_ff)))
      else $error("rejected frame changed state");

   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> ($stable(lamps_ff) && $stable(tx_ctr_ff)))
      else $error("state moved without a transaction");

endmodule
`default_nettype wire

### design/gear_selector_frame_controller.sv
// gear_selector_frame_controller: top level with configuration registers, front,
// command queue and back. Depends on gsfc_pkg, gsfc_front, gsfc_cmdq, gsfc_back.
//
// Usage:
//  - request side is a queue: drive req_* fields with req_push while req_full is low.
//    req_cmd 0 is a received bus frame, 1 a transmit tick.
//  - response side is a queue: the oldest result sits on rsp_* while rsp_empty is low
//    and leaves on rsp_pop. Every transaction gives exactly one result.
//  - csr_we/csr_index/csr_wdata write tx_frame_id (0), rx_frame_id (1), tx_seed (2);
//    write only while the block is drained.
//  - the edge that accepts a request writes it into the command queue; the back end
//    then moves its result into the result queue when that queue has room, and the
//    result sits on rsp_* until it is popped.
//  - throughput: one transaction per cycle while the result queue has room; the lamp
//    update and the frame build are both combinational in the back end.
//  - when rsp_pop stays low the four-entry result queue fills, the back end stops,
//    then the four-entry command queue fills and req_full rises.
//  - reset (synchronous) empties both queues, restores the register defaults,
//    lamps P on, R and D backlit, N and B off, lever word and counter zero.
`timescale 1ns / 1ps
`default_nettype none
module gear_selector_frame_controller (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic                           req_cmd,
   input  wire logic [31:0]                    req_frame_id,
   input  wire logic [3:0]                     req_frame_len,
   input  wire logic [7:0]                     req_rx_byte0,
   input  wire logic [7:0]                     req_rx_byte1,
   input  wire logic [7:0]                     req_rx_byte2,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic                                rsp_kind,
   output logic [63:0]                         rsp_tx_data,
   output logic [10:0]                         rsp_tx_id_out,
   output logic [2:0]                          rsp_p_lamp,
   output logic [2:0]                          rsp_r_lamp,
   output logic [2:0]                          rsp_n_lamp,
   output logic [2:0]                          rsp_d_lamp,
   output logic [2:0]                          rsp_b_lamp,
   output logic [2:0]                          rsp_rx_status,
   input  wire logic                           csr_we,
   input  wire logic [gsfc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [gsfc_pkg::CSR_DW-1:0]    csr_wdata
);

   logic [gsfc_pkg::TX_ID_W-1:0] tx_id_ff, tx_id_in;
   logic [gsfc_pkg::RX_ID_W-1:0] rx_id_ff, rx_id_in;
   logic [gsfc_pkg::SEED_W-1:0]  seed_ff, seed_in;

   logic              cq_full, cq_push, cq_pop, cq_empty;
   gsfc_pkg::cmd_type cq_din, cq_dout;
   gsfc_pkg::res_type res;

   always_comb begin
      tx_id_in = tx_id_ff;
      rx_id_in = rx_id_ff;
      seed_in  = seed_ff;
      if (csr_we) begin
         unique case (csr_index)
            gsfc_pkg::CSR_TX_ID: tx_id_in = csr_wdata[gsfc_pkg::TX_ID_W-1:0];
            gsfc_pkg::CSR_RX_ID: rx_id_in = csr_wdata[gsfc_pkg::RX_ID_W-1:0];
            gsfc_pkg::CSR_SEED:  seed_in  = csr_wdata[gsfc_pkg::SEED_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_id_ff <= gsfc_pkg::TX_ID_RST;
         rx_id_ff <= gsfc_pkg::RX_ID_RST;
         seed_ff  <= gsfc_pkg::SEED_RST;
      end else begin
         tx_id_ff <= tx_id_in;
         rx_id_ff <= rx_id_in;
         seed_ff  <= seed_in;
      end
   end

   gsfc_front u_front (
      .req_push      (req_push),
      .req_full      (req_full),
      .req_cmd       (req_cmd),
      .req_frame_id  (req_frame_id),
      .req_frame_len (req_frame_len),
      .req_rx_byte0  (req_rx_byte0),
      .req_rx_byte1  (req_rx_byte1),
      .req_rx_byte2  (req_rx_byte2),
      .rx_frame_id   (rx_id_ff),
      .cq_full       (cq_full),
      .cq_push       (cq_push),
      .cq_cmd        (cq_din)
   );

   gsfc_cmdq u_cmdq (
      .clock (clock),
      .reset (reset),
      .push  (cq_push),
      .din   (cq_din),
      .full  (cq_full),
      .pop   (cq_pop),
      .dout  (cq_dout),
      .empty (cq_empty)
   );

   gsfc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cq_dout),
      .cq_empty    (cq_empty),
      .cq_pop      (cq_pop),
      .tx_frame_id (tx_id_ff),
      .tx_seed     (seed_ff),
      .res_pop     (rsp_pop),
      .res_empty   (rsp_empty),
      .res         (res)
   );

   assign rsp_kind      = res.kind;
   assign rsp_tx_data   = res.tx_data;
   assign rsp_tx_id_out = res.tx_id;
   assign rsp_p_lamp    = res.lamps.p;
   assign rsp_r_lamp    = res.lamps.r;
   assign rsp_n_lamp    = res.lamps.n;
   assign rsp_d_lamp    = res.lamps.d;
   assign rsp_b_lamp    = res.lamps.b;
   assign rsp_rx_status = res.status;

endmodule
`default_nettype wire

### bench/gsfc_tb_pkg.sv
// gsfc_tb_pkg: transaction type, checksum helper and the lamp/frame scoreboard
// for the gear selector frame controller bench. Depends on gsfc_pkg.
`timescale 1ns / 1ps
package gsfc_tb_pkg;
   import gsfc_pkg::*;

   localparam logic CMD_FRAME = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   typedef struct {
      logic        cmd;
      logic [31:0] frame_id;
      logic [3:0]  frame_len;
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      logic [7:0]  byte2;
   } selector_item;

   // nibble sum over the low count bytes, folded with counter and seed
   function automatic logic [7:0] nibble_checksum(logic [63:0] bytes, int count,
                                                  logic [3:0] ctr, logic [7:0] seed);
      logic [7:0] acc;
      logic [7:0] u;
      acc = 8'd0;
      for (int i = 0; i < count; i++)
         acc = acc + bytes[8*i +: 4] + bytes[8*i+4 +: 4];
      acc = acc + ctr;
      u = (acc ^ 8'hFF) - seed;
      return {u[3:0], ctr};
   endfunction

   function automatic lamps_type lamp_set(lamp_type p, lamp_type r, lamp_type n,
                                          lamp_type d, lamp_type b);
      lamps_type l;
      l.p = p;
      l.r = r;
      l.n = n;
      l.d = d;
      l.b = b;
      return l;
   endfunction

   class gear_lamp_scoreboard;
      lamps_type          lamps;
      logic [15:0]        last_word;
      logic [3:0]         tx_count;
      logic [TX_ID_W-1:0] tx_id;
      logic [RX_ID_W-1:0] rx_id;
      logic [SEED_W-1:0]  seed;
      res_type            awaited_results[$];
      int                 errors;

      function new();
         lamps     = lamp_set(LAMP_ON, LAMP_BACKLIT, LAMP_OFF, LAMP_BACKLIT, LAMP_OFF);
         last_word = 16'd0;
         tx_count  = 4'd0;
         tx_id     = TX_ID_RST;
         rx_id     = RX_ID_RST;
         seed      = SEED_RST;
         errors    = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DW-1:0] data);
         case (idx)
            CSR_TX_ID: tx_id = data[TX_ID_W-1:0];
            CSR_RX_ID: rx_id = data[RX_ID_W-1:0];
            CSR_SEED:  seed  = data[SEED_W-1:0];
            default: ;
         endcase
      endfunction

      function void apply_lever(logic [15:0] w);
         logic       neutral_check;
         logic [3:0] pos;
         neutral_check = 1'b0;
         pos = w[15:12];
         if (pos == POS_D_FULL) begin
            lamps = lamp_set(LAMP_OFF, LAMP_BACKLIT, LAMP_BACKLIT, LAMP_ON, LAMP_BACKLIT);
         end else if (pos == POS_R_FULL) begin
            lamps = lamp_set(LAMP_OFF, LAMP_ON, LAMP_BACKLIT, LAMP_BACKLIT, LAMP_OFF);
            neutral_check = 1'b1;
         end else if (pos == POS_R_LITTLE || pos == POS_D_LITTLE) begin
            neutral_check = 1'b1;
         end
         // reverse falls into the neutral rule with the lamps it just set
         if (neutral_check && (lamps.r == LAMP_ON || lamps.d == LAMP_ON) &&
             !w[LEVER_CHANGE_BIT])
            lamps = lamp_set(LAMP_BACKLIT, LAMP_BACKLIT, LAMP_ON, LAMP_BACKLIT, LAMP_OFF);
         if (w[LEVER_P_BIT] && lamps.n == LAMP_ON)
            lamps = lamp_set(LAMP_ON, LAMP_BACKLIT, LAMP_OFF, LAMP_BACKLIT, LAMP_OFF);
         if (w[LEVER_B_BIT] && lamps.d == LAMP_ON)
            lamps.b = (lamps.b == LAMP_ON) ? LAMP_BACKLIT : LAMP_ON;
      endfunction

      function void note_request(selector_item item);
         res_type     res;
         logic [31:0] word;
         logic [15:0] w;
         res.kind    = 1'b0;
         res.tx_data = 64'd0;
         res.tx_id   = '0;
         res.status  = ST_OTHER;
         if (item.cmd == CMD_TICK) begin
            word = ({29'd0, lamps.p} << 1) | ({29'd0, lamps.d} << 8) |
                   ({29'd0, lamps.n} << 11) | ({29'd0, lamps.r} << 14) |
                   ({29'd0, lamps.b} << 21);
            res.tx_data = {24'd0, word,
                           nibble_checksum({24'd0, word, 8'd0}, 8, tx_count, seed)};
            res.tx_id   = tx_id;
            res.kind    = 1'b1;
            tx_count    = tx_count + 4'd1;
         end else if (item.frame_id != {21'd0, rx_id}) begin
            res.status = ST_OTHER;
         end else if (item.frame_len != RX_LEN) begin
            res.status = ST_LEN_BAD;
         end else if (nibble_checksum({48'd0, item.byte2, item.byte1}, 2,
                                      item.byte0[3:0], 8'd0) != item.byte0) begin
            res.status = ST_CK_BAD;
         end else begin
            w = {item.byte1, item.byte2};
            if (w != last_word) begin
               apply_lever(w);
               res.status = ST_CHANGED;
            end else begin
               res.status = ST_SAME;
            end
            last_word = w;
         end
         res.lamps = lamps;
         awaited_results.push_back(res);
      endfunction

      task report_error(string msg);
         errors++;
         if (errors <= 40)
            $display("%0t ERROR: %s", $realtime, msg);
      endtask

      task compare_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            report_error($sformatf("%s got %0h expected %0h", name, got, want));
      endtask

      task check_response(res_type got);
         res_type want;
         if (awaited_results.size() == 0) begin
            report_error("result with no transaction waiting");
         end else begin
            want = awaited_results.pop_front();
            compare_field("kind", got.kind, want.kind);
            compare_field("tx_data", got.tx_data, want.tx_data);
            compare_field("tx_id_out", got.tx_id, want.tx_id);
            compare_field("p_lamp", got.lamps.p, want.lamps.p);
            compare_field("r_lamp", got.lamps.r, want.lamps.r);
            compare_field("n_lamp", got.lamps.n, want.lamps.n);
            compare_field("d_lamp", got.lamps.d, want.lamps.d);
            compare_field("b_lamp", got.lamps.b, want.lamps.b);
            compare_field("rx_status", got.status, want.status);
         end
      endtask

      function bit drained();
         return awaited_results.size() == 0;
      endfunction
   endclass

endpackage

### bench/tb_top.sv
// tb_top: drives received frames, transmit ticks and register writes into the
// gear selector frame controller and checks every result. Depends on gsfc_pkg, gsfc_tb_pkg.
`timescale 1ns / 1ps
module tb_top;
   import gsfc_pkg::*;
   import gsfc_tb_pkg::*;

   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 216;
   localparam int STALL_LIMIT     = 4000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic                 req_cmd = CMD_FRAME;
   logic [31:0]          req_frame_id = 32'd0;
   logic [3:0]           req_frame_len = 4'd0;
   logic [7:0]           req_rx_byte0 = 8'd0;
   logic [7:0]           req_rx_byte1 = 8'd0;
   logic [7:0]           req_rx_byte2 = 8'd0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic                 rsp_kind;
   logic [63:0]          rsp_tx_data;
   logic [10:0]          rsp_tx_id_out;
   logic [2:0]           rsp_p_lamp;
   logic [2:0]           rsp_r_lamp;
   logic [2:0]           rsp_n_lamp;
   logic [2:0]           rsp_d_lamp;
   logic [2:0]           rsp_b_lamp;
   logic [2:0]           rsp_rx_status;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_TX_ID;
   logic [CSR_DW-1:0]    csr_wdata = '0;

   gear_lamp_scoreboard sb = new();
   int                  send_idle_pct = 0;
   int                  recv_stall_pct = 0;
   logic [RX_ID_W-1:0]  rx_id_now = RX_ID_RST;
   logic [15:0]         last_word_sent = 16'd0;

   gear_selector_frame_controller u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_cmd       (req_cmd),
      .req_frame_id  (req_frame_id),
      .req_frame_len (req_frame_len),
      .req_rx_byte0  (req_rx_byte0),
      .req_rx_byte1  (req_rx_byte1),
      .req_rx_byte2  (req_rx_byte2),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_kind      (rsp_kind),
      .rsp_tx_data   (rsp_tx_data),
      .rsp_tx_id_out (rsp_tx_id_out),
      .rsp_p_lamp    (rsp_p_lamp),
      .rsp_r_lamp    (rsp_r_lamp),
      .rsp_n_lamp    (rsp_n_lamp),
      .rsp_d_lamp    (rsp_d_lamp),
      .rsp_b_lamp    (rsp_b_lamp),
      .rsp_rx_status (rsp_rx_status),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // result side: check what leaves at this edge, then pick the next pop
   always @(posedge clock) begin : rsp_monitor
      res_type got;
      if (!reset && rsp_pop && rsp_empty === 1'b0) begin
         got.kind    = rsp_kind;
         got.tx_data = rsp_tx_data;
         got.tx_id   = rsp_tx_id_out;
         got.lamps.p = lamp_type'(rsp_p_lamp);
         got.lamps.r = lamp_type'(rsp_r_lamp);
         got.lamps.n = lamp_type'(rsp_n_lamp);
         got.lamps.d = lamp_type'(rsp_d_lamp);
         got.lamps.b = lamp_type'(rsp_b_lamp);
         got.status  = status_type'(rsp_rx_status);
         sb.check_response(got);
      end
      rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_push && !req_full) || (rsp_pop && !rsp_empty))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   task send_item(selector_item item);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_cmd       <= item.cmd;
      req_frame_id  <= item.frame_id;
      req_frame_len <= item.frame_len;
      req_rx_byte0  <= item.byte0;
      req_rx_byte1  <= item.byte1;
      req_rx_byte2  <= item.byte2;
      do @(posedge clock); while (req_full !== 1'b0);
      sb.note_request(item);
   endtask

   task write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DW-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task drain();
      req_push <= 1'b0;
      while (!sb.drained()) @(posedge clock);
   endtask

   function automatic selector_item good_frame(logic [15:0] w);
      selector_item item;
      logic [3:0]   ctr;
      ctr            = 4'($urandom_range(15));
      item.cmd       = CMD_FRAME;
      item.frame_id  = {21'd0, rx_id_now};
      item.frame_len = RX_LEN;
      item.byte1     = w[15:8];
      item.byte2     = w[7:0];
      item.byte0     = nibble_checksum({48'd0, w[7:0], w[15:8]}, 2, ctr, 8'd0);
      return item;
   endfunction

   function automatic selector_item tick_item();
      selector_item item;
      item.cmd       = CMD_TICK;
      item.frame_id  = $urandom;
      item.frame_len = 4'($urandom_range(8));
      item.byte0     = 8'($urandom);
      item.byte1     = 8'($urandom);
      item.byte2     = 8'($urandom);
      return item;
   endfunction

   function automatic logic [15:0] lever_word();
      logic [3:0] pos;
      case ($urandom_range(4))
         0: pos = POS_D_FULL;
         1: pos = POS_R_FULL;
         2: pos = POS_R_LITTLE;
         3: pos = POS_D_LITTLE;
         default: pos = 4'($urandom);
      endcase
      return {pos, 12'($urandom)};
   endfunction

   task send_lever(logic [15:0] w);
      last_word_sent = w;
      send_item(good_frame(w));
   endtask

   task random_item();
      selector_item item;
      int           pick;
      logic [15:0]  w;
      pick = $urandom_range(99);
      w    = lever_word();
      if (pick < 15) begin
         item = tick_item();
      end else if (pick < 70) begin
         last_word_sent = w;
         item = good_frame(w);
      end else if (pick < 80) begin
         item = good_frame(last_word_sent);
      end else if (pick < 85) begin
         item = good_frame(w);
         item.byte0 = item.byte0 ^ {4'($urandom_range(1, 15)), 4'd0};
      end else if (pick < 90) begin
         item = good_frame(w);
         item.frame_len = 4'($urandom_range(7));
         if (item.frame_len >= RX_LEN)
            item.frame_len = item.frame_len + 4'd1;
      end else if (pick < 95) begin
         item = good_frame(w);
         case ($urandom_range(2))
            0: item.frame_id = {2'($urandom_range(1, 3)), 19'd0, rx_id_now};
            1: item.frame_id = {21'd0, rx_id_now ^ 11'($urandom_range(1, 2047))};
            default: item.frame_id = $urandom;
         endcase
      end else begin
         // anything at all
         item = tick_item();
         item.cmd = 1'($urandom);
      end
      send_item(item);
   endtask

   task directed_items();
      selector_item item;
      send_item(tick_item());
      send_lever(16'h0000);                   // same as the reset word
      send_lever(16'h8000);                   // full drive
      send_lever(16'h8040);                   // brake toggle with drive on
      send_item(tick_item());
      send_lever(16'h4000);                   // full reverse into the neutral rule
      send_lever(16'h4400);                   // reverse with the change bit held
      send_lever(16'h2000);                   // light reverse, neutral
      send_lever(16'h0100);                   // park from neutral
      send_lever(16'h8000);
      send_lever(16'h6000);                   // light drive, neutral
      send_lever(16'hFFFF);
      send_lever(16'h0000);
      item = good_frame(16'h1234);
      item.byte0 = item.byte0 ^ 8'hF0;        // checksum nibble wrong
      send_item(item);
      item = good_frame(16'h8000);
      item.frame_len = 4'd0;
      send_item(item);
      item.frame_len = 4'd8;
      send_item(item);
      item = good_frame(16'h8000);
      item.frame_id[31] = 1'b1;               // extended flag never matches
      send_item(item);
      item.frame_id[31] = 1'b0;
      item.frame_id[30] = 1'b1;               // remote flag
      send_item(item);
      item.frame_id = 32'hFFFF_FFFF;
      send_item(item);
      item = good_frame(16'hFFFF);
      item.frame_id = 32'd0;
      send_item(item);
      item.cmd   = CMD_TICK;
      item.byte0 = 8'hFF;
      send_item(item);
      send_item(tick_item());
   endtask

   initial begin : stimulus
      logic [TX_ID_W-1:0] tx_id_set;
      logic [RX_ID_W-1:0] rx_id_set;
      logic [SEED_W-1:0]  seed_set;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_items();
      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph)
            0: begin
               tx_id_set = TX_ID_RST;
               rx_id_set = RX_ID_RST;
               seed_set  = SEED_RST;
            end
            1: begin
               tx_id_set = '0;
               rx_id_set = '0;
               seed_set  = '0;
            end
            2: begin
               tx_id_set = '1;
               rx_id_set = '1;
               seed_set  = '1;
            end
            default: begin
               tx_id_set = 11'($urandom);
               rx_id_set = 11'($urandom);
               seed_set  = 8'($urandom);
            end
         endcase
         write_reg(CSR_TX_ID, CSR_DW'(tx_id_set));
         write_reg(CSR_RX_ID, CSR_DW'(rx_id_set));
         write_reg(CSR_SEED, CSR_DW'(seed_set));
         csr_we    <= 1'b0;
         rx_id_now  = rx_id_set;
         case (ph % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 68;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 68;
            end
            default: begin
               send_idle_pct  = 36;
               recv_stall_pct = 36;
            end
         endcase
         for (int i = 0; i < ITEMS_PER_PHASE; i++)
            random_item();
      end
      drain();
      repeat (8) @(posedge clock);
      if (sb.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

### sim.f
design/gsfc_pkg.sv
design/gsfc_front.sv
design/gsfc_cmdq.sv
design/gsfc_back.sv
design/gear_selector_frame_controller.sv
bench/gsfc_tb_pkg.sv
bench/tb_top.sv
